// ===== design/rmm_pkg.sv =====
// Shared constants, types and control/status structs for the reachability matrix block.
package rmm_pkg;

    localparam int NODES   = 64;
    localparam int IDX_W   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int AREA_W  = 6;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 7;

    typedef logic [NODES-1:0]   row_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam kind_t KIND_LINK  = 2'd0;
    localparam kind_t KIND_FUSE  = 2'd1;
    localparam kind_t KIND_QUERY = 2'd2;
    localparam kind_t KIND_CLEAR = 2'd3;

    localparam count_t COUNT_RESET = 7'd64;

    typedef struct packed {
        logic load;
        logic clear;
        logic rd_pair;
        logic sweep_rd;
        logic sweep_wr;
        logic wr_link;
        logic gain_load;
        logic cnt_clr;
        logic kill_o;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  ok;
        logic  cnt_last;
        logic  cnt_zero;
        logic  out_blocked;
    } stat_t;

endpackage

// ===== design/rmm_dpath.sv =====
// Datapath: row memory, valid bits, alive mask, fuse gains, sweep counter, result register.
module rmm_dpath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   area_count_we,
    input  rmm_pkg::count_t        area_count,
    input  rmm_pkg::kind_t         kind,
    input  logic [rmm_pkg::AREA_W-1:0] first_area,
    input  logic [rmm_pkg::AREA_W-1:0] second_area,
    input  rmm_pkg::cmd_t          cmd,
    output rmm_pkg::stat_t         stat,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic                   reach_bit
);

    localparam logic [rmm_pkg::COUNT_W-1:0] NODES_C = rmm_pkg::COUNT_W'(rmm_pkg::NODES);
    localparam rmm_pkg::count_t COUNT_RESET_C = rmm_pkg::COUNT_RESET;

    rmm_pkg::row_t   mem_q [rmm_pkg::NODES];
    rmm_pkg::row_t   valid_reg;
    rmm_pkg::row_t   alive_reg;
    rmm_pkg::row_t   alive_clr;
    rmm_pkg::count_t area_count_reg;

    rmm_pkg::kind_t  kind_reg;
    rmm_pkg::idx_t   t_reg;
    rmm_pkg::idx_t   o_reg;
    logic            ok_reg;

    rmm_pkg::row_t   a_data_reg;
    rmm_pkg::row_t   b_data_reg;
    logic            a_vld_reg;
    logic            b_vld_reg;
    rmm_pkg::idx_t   a_addr_reg;
    rmm_pkg::row_t   row_a;
    rmm_pkg::row_t   row_b;

    rmm_pkg::row_t   gain_pre_reg;
    rmm_pkg::row_t   gain_post_reg;
    rmm_pkg::row_t   gain_pre_next;
    rmm_pkg::row_t   t_new;

    rmm_pkg::idx_t   cnt_reg;
    rmm_pkg::idx_t   cnt_next;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic            reach_bit_reg;
    logic            bit_next;

    rmm_pkg::idx_t   rd_addr;
    logic            rd_en;
    logic            we;
    rmm_pkg::idx_t   waddr;
    rmm_pkg::row_t   wdata;
    rmm_pkg::row_t   sweep_gain;

    // clear mask: nodes below area_count, saturating at NODES
    always_comb
    begin
        for (int i = 0; i < rmm_pkg::NODES; i++)
        begin
            alive_clr[i] = (rmm_pkg::COUNT_W'(i) < area_count_reg);
        end
    end

    assign row_a = a_vld_reg ? a_data_reg : (rmm_pkg::row_t'(1) << a_addr_reg);
    assign row_b = b_vld_reg ? b_data_reg : (rmm_pkg::row_t'(1) << o_reg);

    assign rd_addr = cmd.sweep_rd ? cnt_reg : t_reg;
    assign rd_en   = cmd.rd_pair | cmd.sweep_rd;

    always_comb
    begin
        sweep_gain = '0;
        if (alive_reg[a_addr_reg])
        begin
            if (row_a[t_reg])
                sweep_gain = gain_pre_reg;
            else if (row_a[o_reg])
                sweep_gain = gain_post_reg;
        end
    end

    assign we    = cmd.wr_link | cmd.sweep_wr;
    assign waddr = cmd.wr_link ? t_reg : a_addr_reg;
    assign wdata = cmd.wr_link ? (row_a | (row_b & alive_reg)) : (row_a | sweep_gain);

    assign gain_pre_next = row_b & alive_reg & ~row_a;
    assign t_new         = alive_reg[t_reg] ? (row_a | gain_pre_next) : row_a;

    assign cnt_next = cmd.cnt_clr ? '0 : (cmd.sweep_rd ? cnt_reg + 1'b1 : cnt_reg);

    assign bit_next = (kind_reg == rmm_pkg::KIND_QUERY) && ok_reg && row_a[o_reg];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem_q[waddr] <= wdata;
        if (rd_en)
        begin
            a_data_reg <= mem_q[rd_addr];
            b_data_reg <= mem_q[o_reg];
            a_vld_reg  <= valid_reg[rd_addr];
            b_vld_reg  <= valid_reg[o_reg];
            a_addr_reg <= rd_addr;
        end
        if (cmd.load)
        begin
            kind_reg <= kind;
            t_reg    <= first_area[rmm_pkg::IDX_W-1:0];
            o_reg    <= second_area[rmm_pkg::IDX_W-1:0];
            ok_reg   <= ({1'b0, first_area} < NODES_C) && ({1'b0, second_area} < NODES_C);
        end
        if (cmd.gain_load)
        begin
            gain_pre_reg  <= gain_pre_next;
            gain_post_reg <= t_new & alive_reg;
        end
        if (cmd.res_load)
            reach_bit_reg <= bit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            alive_reg      <= '1;
            area_count_reg <= COUNT_RESET_C;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (area_count_we)
                area_count_reg <= area_count;
            if (cmd.clear)
            begin
                valid_reg <= '0;
                alive_reg <= alive_clr;
            end
            else
            begin
                if (we)
                    valid_reg[waddr] <= 1'b1;
                if (cmd.kill_o)
                    alive_reg[o_reg] <= 1'b0;
            end
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.kind        = kind_reg;
    assign stat.ok          = ok_reg;
    assign stat.cnt_last    = (cnt_reg == rmm_pkg::IDX_W'(rmm_pkg::NODES - 1));
    assign stat.cnt_zero    = (cnt_reg == '0);
    assign stat.out_blocked = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign reach_bit = reach_bit_reg;

    a_clear_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (valid_reg == '0))
        else $error("valid bits not cleared");

    a_kill_o: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.kill_o |=> !alive_reg[o_reg])
        else $error("merged node still alive");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_link |-> !cmd.sweep_wr && !cmd.clear)
        else $error("conflicting row writes");

endmodule

// ===== design/rmm_ctrl.sv =====
// Controller state machine: sequences link, fuse sweep, query, clear and result transfer.
module rmm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rmm_pkg::stat_t stat,
    output rmm_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_LINK   = 3'd2;
    localparam logic [2:0] ST_PREP   = 3'd3;
    localparam logic [2:0] ST_SWEEP  = 3'd4;
    localparam logic [2:0] ST_SW_END = 3'd5;
    localparam logic [2:0] ST_RES    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.kind == rmm_pkg::KIND_CLEAR)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_RES;
                end
                else if (!stat.ok)
                    state_next = ST_RES;
                else
                begin
                    cmd.rd_pair = 1'b1;
                    if (stat.kind == rmm_pkg::KIND_LINK)
                        state_next = ST_LINK;
                    else if (stat.kind == rmm_pkg::KIND_FUSE)
                        state_next = ST_PREP;
                    else
                        state_next = ST_RES;
                end
            end
            ST_LINK:
            begin
                cmd.wr_link = 1'b1;
                state_next  = ST_RES;
            end
            ST_PREP:
            begin
                cmd.gain_load = 1'b1;
                cmd.cnt_clr   = 1'b1;
                state_next    = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                cmd.sweep_rd = 1'b1;
                cmd.sweep_wr = !stat.cnt_zero;
                if (stat.cnt_last)
                    state_next = ST_SW_END;
            end
            ST_SW_END:
            begin
                cmd.sweep_wr = 1'b1;
                cmd.kill_o   = 1'b1;
                state_next   = ST_RES;
            end
            ST_RES:
            begin
                if (!stat.out_blocked)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted transfer not decoded");

    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && stat.cnt_last) |=> (state_reg == ST_SW_END))
        else $error("sweep did not finish after last row");

    a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !stat.out_blocked)
        else $error("result loaded over pending transfer");

endmodule

// ===== design/reachability_matrix_merge.sv =====
// Top level: reachability bit matrix with link, fuse, query and clear items.
// States from input transfer to result load: query and clear pass DECODE and RES, link
// adds LINK, fuse adds PREP, SWEEP and SW_END (one row read-modify-write per cycle).
// One item at a time; the next item is taken the cycle after its result is loaded,
// and a stalled output holds the block in RES until the previous result is taken.
// Reset: matrix reads as identity, area_count is 64 and all nodes are alive.
module reachability_matrix_merge (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       area_count_we,
    input  logic [rmm_pkg::COUNT_W-1:0] area_count,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rmm_pkg::KIND_W-1:0] kind,
    input  logic [rmm_pkg::AREA_W-1:0] first_area,
    input  logic [rmm_pkg::AREA_W-1:0] second_area,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       reach_bit
);

    rmm_pkg::cmd_t  cmd;
    rmm_pkg::stat_t stat;

    rmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rmm_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .area_count_we (area_count_we),
        .area_count    (area_count),
        .kind          (kind),
        .first_area    (first_area),
        .second_area   (second_area),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .reach_bit     (reach_bit)
    );

endmodule

// ===== tb/reachability_matrix_merge_tb.sv =====
// Testbench for reachability_matrix_merge: directed and random items against a predictor.
`timescale 1ns / 100ps

module reachability_matrix_merge_tb;

    logic                         clk;
    logic                         rst_n;
    logic                         area_count_we;
    logic [rmm_pkg::COUNT_W-1:0]  area_count;
    logic                         in_valid;
    logic                         in_ready;
    logic [rmm_pkg::KIND_W-1:0]   kind;
    logic [rmm_pkg::AREA_W-1:0]   first_area;
    logic [rmm_pkg::AREA_W-1:0]   second_area;
    logic                         out_valid;
    logic                         out_ready;
    logic                         reach_bit;

    rmm_pkg::row_t   pred_rows [rmm_pkg::NODES];
    rmm_pkg::row_t   pred_alive;
    rmm_pkg::count_t pred_count;

    logic   reach_expected [$];
    int     send_idle_pct;
    int     recv_idle_pct;
    int     mismatch_count;
    int     items_sent;
    int     fuses_sent;
    int     results_checked;
    int     config_writes;

    reachability_matrix_merge dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .area_count_we (area_count_we),
        .area_count    (area_count),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .first_area    (first_area),
        .second_area   (second_area),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .reach_bit     (reach_bit)
    );

    always #1 clk = ~clk;

    function automatic void clear_pred();
        int n;
        n = (pred_count > rmm_pkg::NODES) ? rmm_pkg::NODES : int'(pred_count);
        for (int i = 0; i < rmm_pkg::NODES; i++)
        begin
            pred_rows[i] = rmm_pkg::row_t'(1) << i;
        end
        if (n >= rmm_pkg::NODES)
            pred_alive = '1;
        else
            pred_alive = (rmm_pkg::row_t'(1) << n) - rmm_pkg::row_t'(1);
    endfunction

    function automatic void fuse_pred(int t, int o);
        rmm_pkg::row_t gain_pre;
        rmm_pkg::row_t gain_post;
        rmm_pkg::row_t t_new;
        gain_pre = pred_rows[o] & pred_alive & ~pred_rows[t];
        t_new = pred_rows[t];
        if (pred_alive[t])
            t_new = pred_rows[t] | gain_pre;
        gain_post = t_new & pred_alive;
        for (int r = 0; r < rmm_pkg::NODES; r++)
        begin
            if (pred_alive[r])
            begin
                if (pred_rows[r][t])
                    pred_rows[r] = pred_rows[r] | gain_pre;
                else if (pred_rows[r][o])
                    pred_rows[r] = pred_rows[r] | gain_post;
            end
        end
        pred_alive[o] = 1'b0;
    endfunction

    function automatic logic predict_reach(rmm_pkg::kind_t k,
                                           logic [rmm_pkg::AREA_W-1:0] a,
                                           logic [rmm_pkg::AREA_W-1:0] b);
        logic in_range;
        logic bit_out;
        in_range = (int'(a) < rmm_pkg::NODES) && (int'(b) < rmm_pkg::NODES);
        bit_out = 1'b0;
        unique case (k)
            rmm_pkg::KIND_LINK:
                if (in_range)
                    pred_rows[a] = pred_rows[a] | (pred_rows[b] & pred_alive);
            rmm_pkg::KIND_FUSE:
                if (in_range)
                    fuse_pred(int'(a), int'(b));
            rmm_pkg::KIND_QUERY:
                if (in_range)
                    bit_out = pred_rows[a][b];
            default:
                clear_pred();
        endcase
        return bit_out;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (reach_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result transfer, reach_bit=%b", $realtime,
                             reach_bit);
            end
            else if (reach_bit !== reach_expected[0])
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: reach_bit mismatch, expected %b actual %b", $realtime,
                             reach_expected[0], reach_bit);
                void'(reach_expected.pop_front());
            end
            else
            begin
                void'(reach_expected.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(input rmm_pkg::kind_t k, input logic [rmm_pkg::AREA_W-1:0] a,
                             input logic [rmm_pkg::AREA_W-1:0] b);
        logic exp_bit;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        exp_bit = predict_reach(k, a, b);
        reach_expected = {reach_expected, exp_bit};
        kind        <= k;
        first_area  <= a;
        second_area <= b;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (k == rmm_pkg::KIND_FUSE)
            fuses_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (reach_expected.size() != 0)
            @(posedge clk);
    endtask

    // only called while idle; each call is followed by a send
    task automatic write_area_count(input rmm_pkg::count_t v);
        area_count    <= v;
        area_count_we <= 1'b1;
        @(posedge clk);
        area_count_we <= 1'b0;
        pred_count = v;
        config_writes++;
    endtask

    task automatic test_link_fuse();
        send_item(rmm_pkg::KIND_QUERY, 6'd0, 6'd0);
        send_item(rmm_pkg::KIND_QUERY, 6'd63, 6'd63);
        send_item(rmm_pkg::KIND_QUERY, 6'd0, 6'd63);
        send_item(rmm_pkg::KIND_LINK, 6'd0, 6'd1);
        send_item(rmm_pkg::KIND_LINK, 6'd1, 6'd2);
        send_item(rmm_pkg::KIND_LINK, 6'd63, 6'd0);
        send_item(rmm_pkg::KIND_QUERY, 6'd0, 6'd2);
        send_item(rmm_pkg::KIND_FUSE, 6'd2, 6'd1);
        send_item(rmm_pkg::KIND_QUERY, 6'd63, 6'd2);
        send_item(rmm_pkg::KIND_FUSE, 6'd5, 6'd5);
        send_item(rmm_pkg::KIND_LINK, 6'd10, 6'd5);
        send_item(rmm_pkg::KIND_QUERY, 6'd5, 6'd5);
        send_item(rmm_pkg::KIND_FUSE, 6'd0, 6'd63);
        send_item(rmm_pkg::KIND_QUERY, 6'd1, 6'd63);
        send_item(rmm_pkg::KIND_CLEAR, 6'd63, 6'd63);
        send_item(rmm_pkg::KIND_QUERY, 6'd0, 6'd1);
        drain();
    endtask

    task automatic test_area_count_extremes();
        rmm_pkg::count_t counts [5];
        logic [rmm_pkg::AREA_W-1:0] top;
        counts = '{7'd0, 7'd1, 7'd63, 7'd127, 7'd64};
        foreach (counts[i])
        begin
            top = (counts[i] == 0) ? 6'd0 :
                  (counts[i] > rmm_pkg::NODES) ? 6'd63 : 6'(counts[i] - 1);
            write_area_count(counts[i]);
            send_item(rmm_pkg::KIND_CLEAR, 6'd0, 6'd0);
            send_item(rmm_pkg::KIND_LINK, 6'd0, top);
            send_item(rmm_pkg::KIND_QUERY, 6'd0, top);
            drain();
        end
    endtask

    task automatic test_random_traffic(input int count);
        rmm_pkg::kind_t k;
        logic [rmm_pkg::AREA_W-1:0] a;
        logic [rmm_pkg::AREA_W-1:0] b;
        int roll;
        int span;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 49)
            begin
                drain();
                case ($urandom_range(5))
                    0: write_area_count(7'd0);
                    1: write_area_count(7'd127);
                    2: write_area_count(7'd1);
                    default: write_area_count(rmm_pkg::count_t'($urandom_range(12, 127)));
                endcase
                if ($urandom_range(3) != 0)
                    send_item(rmm_pkg::KIND_CLEAR, 6'($urandom), 6'($urandom));
            end
            roll = $urandom_range(99);
            k = (roll < 40) ? rmm_pkg::KIND_LINK : (roll < 60) ? rmm_pkg::KIND_FUSE :
                (roll < 96) ? rmm_pkg::KIND_QUERY : rmm_pkg::KIND_CLEAR;
            span = ($urandom_range(4) == 0) ? 63 : 11;
            a = 6'($urandom_range(span));
            b = 6'($urandom_range(span));
            send_item(k, a, b);
        end
        drain();
    endtask

    initial
    begin
        #1000000;
        $display("reachability_matrix_merge verification failed");
        $finish;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        area_count_we  = 1'b0;
        area_count     = rmm_pkg::COUNT_RESET;
        in_valid       = 1'b0;
        kind           = rmm_pkg::KIND_LINK;
        first_area     = '0;
        second_area    = '0;
        out_ready      = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        fuses_sent     = 0;
        results_checked = 0;
        config_writes  = 0;
        send_idle_pct  = 33;
        recv_idle_pct  = 51;
        pred_count     = rmm_pkg::COUNT_RESET;
        clear_pred();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_link_fuse();
        test_area_count_extremes();
        test_random_traffic(135);
        send_idle_pct = 51;
        recv_idle_pct = 33;
        test_random_traffic(135);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(135);

        drain();
        repeat (80) @(posedge clk);

        $display("%0d items (%0d fuses), %0d results checked, %0d area_count writes",
                 items_sent, fuses_sent, results_checked, config_writes);
        $display("%0d mismatches, %0d results still outstanding", mismatch_count,
                 reach_expected.size());
        if (mismatch_count == 0 && reach_expected.size() == 0)
            $display("reachability_matrix_merge verification clean");
        else
            $display("reachability_matrix_merge verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/rmm_pkg.sv
design/rmm_dpath.sv
design/rmm_ctrl.sv
design/reachability_matrix_merge.sv
tb/reachability_matrix_merge_tb.sv
